@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Clocked on i_clk; the first form is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, ignored during reset
`define SHDT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Concurrent check that also holds across reset
`define SHDT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/shdt_pkg.sv @@
// Shared constants and types for the string hash direct table.
// No dependencies; used by every module of the block except shdt_ram.
package shdt_pkg;

    // Table geometry
    localparam int DEPTH   = 1024;
    localparam int VALUE_W = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SIZE_W  = ADDR_W + 1;

    // Hash
    localparam int HASH_W     = 64;
    localparam int KEY_W      = 8;
    localparam int HASH_SHIFT = 5;
    localparam logic [HASH_W-1:0] HASH_INIT = HASH_W'(5381);

    // Size register
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(DEPTH);

    // Remainder unit: bits retired per cycle and step count
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = HASH_W / MOD_BITS;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    // Operation codes
    localparam int OP_W = 2;
    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2,
        OP_WRITE  = 2'd3
    } t_op;

endpackage

@@ rtl/shdt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module shdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/shdt_mod.sv @@
// Iterative remainder unit: 64-bit hash mod table size, MOD_BITS bits a cycle.
// Depends on shdt_pkg.
module shdt_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [shdt_pkg::HASH_W-1:0]   i_dividend,
    input  logic [shdt_pkg::SIZE_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [shdt_pkg::ADDR_W-1:0]   o_rem
);

    logic                             r_busy;
    logic                             r_done;
    logic [shdt_pkg::MOD_CNT_W-1:0]   r_cnt;
    logic [shdt_pkg::HASH_W-1:0]      r_dvd;
    logic [shdt_pkg::ADDR_W-1:0]      r_rem;
    logic [shdt_pkg::ADDR_W-1:0]      n_rem;

    // Restoring remainder over the top MOD_BITS dividend bits; remainder < divisor
    always_comb begin
        logic [shdt_pkg::SIZE_W-1:0] v_t;
        logic [shdt_pkg::ADDR_W-1:0] v_rem;
        v_rem = r_rem;
        for (int k = 0; k < shdt_pkg::MOD_BITS; k++) begin
            v_t = {v_rem, r_dvd[shdt_pkg::HASH_W-1-k]};
            if (v_t >= i_divisor) begin
                v_t = v_t - i_divisor;
            end
            v_rem = v_t[shdt_pkg::ADDR_W-1:0];
        end
        n_rem = v_rem;
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == shdt_pkg::MOD_CNT_W'(shdt_pkg::MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend shifter and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << shdt_pkg::MOD_BITS;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ rtl/string_hash_direct_table.sv @@
// Direct-mapped value table addressed by a djb2 hash of a byte-streamed key.
// Lookup and insert hash the key through the remainder unit before the table access;
// a by-index read or write goes to the table directly, and an out-of-range index gets
// a result with o_ok low without one. A non-final key byte gives no result. One item
// at a time: no new item is taken until a result is loaded, so a stalled one delays it.
// Reset clears the table with a pass over every entry; o_in_ready stays low until done.
module string_hash_direct_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [shdt_pkg::SIZE_W-1:0]     i_cfg_wdata,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [shdt_pkg::OP_W-1:0]       i_op,
    input  logic [shdt_pkg::KEY_W-1:0]      i_key_byte,
    input  logic                            i_byte_present,
    input  logic                            i_key_last,
    input  logic [shdt_pkg::ADDR_W-1:0]     i_entry_index,
    input  logic [shdt_pkg::VALUE_W-1:0]    i_item_value,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [shdt_pkg::ADDR_W-1:0]     o_slot_index,
    output logic [shdt_pkg::VALUE_W-1:0]    o_read_value,
    output logic                            o_found,
    output logic                            o_ok
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_DIV    = 6'b000100,
        S_ACCESS = 6'b001000,
        S_RDATA  = 6'b010000,
        S_RESP   = 6'b100000
    } t_state;

    t_state                          r_state,    n_state;
    logic [shdt_pkg::ADDR_W-1:0]     r_clr_addr, n_clr_addr;
    logic [shdt_pkg::HASH_W-1:0]     r_hash,     n_hash;
    logic [shdt_pkg::SIZE_W-1:0]     r_cfg;
    logic                            r_write,    n_write;
    logic [shdt_pkg::ADDR_W-1:0]     r_slot,     n_slot;
    logic [shdt_pkg::VALUE_W-1:0]    r_val,      n_val;
    logic [shdt_pkg::VALUE_W-1:0]    r_res_val,  n_res_val;
    logic                            r_res_ok,   n_res_ok;
    logic                            r_out_valid;
    logic [shdt_pkg::ADDR_W-1:0]     r_out_slot;
    logic [shdt_pkg::VALUE_W-1:0]    r_out_val;
    logic                            r_out_found;
    logic                            r_out_ok;

    logic [shdt_pkg::SIZE_W-1:0]     eff_size;
    logic                            in_xfer;
    logic                            out_free;
    logic                            out_load;
    shdt_pkg::t_op                   op;
    logic                            key_op;
    logic                            idx_oor;
    logic [shdt_pkg::HASH_W-1:0]     hash_upd;
    logic [shdt_pkg::HASH_W-1:0]     key_hash;
    logic                            mod_start;
    logic                            mod_done;
    logic [shdt_pkg::ADDR_W-1:0]     mod_rem;
    logic                            ram_we;
    logic [shdt_pkg::ADDR_W-1:0]     ram_waddr;
    logic [shdt_pkg::VALUE_W-1:0]    ram_wdata;
    logic [shdt_pkg::VALUE_W-1:0]    ram_rdata;

    // Size in use: zero acts as one, clipped to the table depth
    always_comb begin
        if (r_cfg == '0) begin
            eff_size = shdt_pkg::SIZE_W'(1);
        end else if (r_cfg > shdt_pkg::SIZE_MAX) begin
            eff_size = shdt_pkg::SIZE_MAX;
        end else begin
            eff_size = r_cfg;
        end
    end

    // Input decode and hash step: hash*33 + byte
    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign op         = shdt_pkg::t_op'(i_op);
    assign key_op     = (op == shdt_pkg::OP_LOOKUP) || (op == shdt_pkg::OP_INSERT);
    assign idx_oor    = {1'b0, i_entry_index} >= eff_size;
    assign hash_upd   = (r_hash << shdt_pkg::HASH_SHIFT) + r_hash
                        + shdt_pkg::HASH_W'(i_key_byte);
    assign key_hash   = i_byte_present ? hash_upd : r_hash;
    assign mod_start  = in_xfer && key_op && i_key_last;
    assign out_free   = !r_out_valid || i_out_ready;
    assign out_load   = (r_state == S_RESP) && out_free;

    shdt_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (key_hash),
        .i_divisor  (eff_size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    shdt_ram #(
        .WIDTH (shdt_pkg::VALUE_W),
        .DEPTH (shdt_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    // Sequencer: one item at a time, so a read never overlaps a write to its entry
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_hash     = r_hash;
        n_write    = r_write;
        n_slot     = r_slot;
        n_val      = r_val;
        n_res_val  = r_res_val;
        n_res_ok   = r_res_ok;
        ram_we     = 1'b0;
        ram_waddr  = r_slot;
        ram_wdata  = r_val;
        case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == shdt_pkg::ADDR_W'(shdt_pkg::DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_val   = i_item_value;
                    n_write = (op == shdt_pkg::OP_INSERT) || (op == shdt_pkg::OP_WRITE);
                    if (!key_op) begin
                        n_slot = i_entry_index;
                        if (idx_oor) begin
                            n_res_val = '0;
                            n_res_ok  = 1'b0;
                            n_state   = S_RESP;
                        end else begin
                            n_res_ok = 1'b1;
                            n_state  = S_ACCESS;
                        end
                    end else if (i_key_last) begin
                        n_hash   = shdt_pkg::HASH_INIT;
                        n_res_ok = 1'b1;
                        n_state  = S_DIV;
                    end else begin
                        n_hash = key_hash;
                    end
                end
            end
            S_DIV: begin
                if (mod_done) begin
                    n_slot  = mod_rem;
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: begin
                if (r_write) begin
                    ram_we    = 1'b1;
                    n_res_val = r_val;
                    n_state   = S_RESP;
                end else begin
                    n_state = S_RDATA;
                end
            end
            S_RDATA: begin
                n_res_val = ram_rdata;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_hash      <= shdt_pkg::HASH_INIT;
            r_cfg       <= shdt_pkg::SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_hash     <= n_hash;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and output payload
    always_ff @(posedge i_clk) begin
        r_write   <= n_write;
        r_slot    <= n_slot;
        r_val     <= n_val;
        r_res_val <= n_res_val;
        r_res_ok  <= n_res_ok;
        if (out_load) begin
            r_out_slot  <= r_slot;
            r_out_val   <= r_res_val;
            r_out_found <= (r_res_val != '0);
            r_out_ok    <= r_res_ok;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_slot_index = r_out_slot;
    assign o_read_value = r_out_val;
    assign o_found      = r_out_found;
    assign o_ok         = r_out_ok;

endmodule

@@ rtl/shdt_checker.sv @@
// Port-level checks for string_hash_direct_table, bound to the top level.
// Depends on assert_macros.svh and shdt_pkg.
`include "assert_macros.svh"

module shdt_port_checks (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [shdt_pkg::ADDR_W-1:0]     o_slot_index,
    input logic [shdt_pkg::VALUE_W-1:0]    o_read_value,
    input logic                            o_found,
    input logic                            o_ok
);

    logic                                             out_stall;
    logic [shdt_pkg::ADDR_W+shdt_pkg::VALUE_W+1:0]    out_payload;

    assign out_stall   = o_out_valid && !i_out_ready;
    assign out_payload = {o_slot_index, o_read_value, o_found, o_ok};

    // A stalled result stays offered
    `SHDT_ASSERT(a_out_hold, out_stall |=> o_out_valid, "result dropped while stalled")

    // A stalled result keeps its payload
    `SHDT_ASSERT(a_out_stable, out_stall |=> $stable(out_payload), "result changed while stalled")

    // found reflects a nonzero entry
    `SHDT_ASSERT(a_found, o_out_valid |-> o_found == (o_read_value != '0), "found mismatch")

    // an out-of-range transfer reports an empty entry
    `SHDT_ASSERT(a_err_zero, o_out_valid && !o_ok |-> o_read_value == '0 && !o_found, "error value")

    // reset starts the clearing pass with both channels quiet
    `SHDT_ASSERT_RST(a_rst_clear, !i_rst_n |=> !o_in_ready && !o_out_valid, "busy after reset")

endmodule

bind string_hash_direct_table shdt_port_checks u_checker (.*);
